// ===== rtl/core/dttf_pkg.sv =====
package dttf_pkg;

  // Fixed-point format of the magnitude and of the result.
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 23;
  localparam int MAG_W     = INT_BITS + FRAC_BITS;
  localparam int VALUE_W   = 40;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int PLACE_W   = FRAC_BITS + 1;

  // Queue between the classifier and the arithmetic stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [PLACE_W-1:0] place_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam mag_t MAG_MAX = {MAG_W{1'b1}};
  localparam logic [63:0] MAG_MAX64 = (64'd1 << MAG_W) - 64'd1;

  // Place value of the first fraction digit: one tenth, truncated.
  localparam place_t PLACE_FIRST = PLACE_W'((64'd1 << FRAC_BITS) / 64'd10);

  // Division of a place value by ten as a multiply by a rounded-up reciprocal.
  // With four guard bits the quotient is exact over the whole place range.
  localparam int DIV10_SHIFT = PLACE_W + 4;
  localparam int DIV10_W     = PLACE_W + 1;
  localparam int DIV10_PROD_W = DIV10_SHIFT + PLACE_W;
  localparam logic [DIV10_W-1:0] DIV10_MUL =
    DIV10_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

  // ASCII codes that the classifier knows.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // Work that one queued item asks of the arithmetic stage.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INT,
    OP_FRAC
  } op_t;

  typedef struct packed {
    op_t    op;
    digit_t digit;
    logic   last;
    logic   bad;
    logic   neg;
  } entry_t;

  // Largest magnitude that may still take an integer digit d without
  // passing the saturation limit.
  function automatic mag_t int_limit(input int unsigned d);
    logic [63:0] lim;
    lim = (MAG_MAX64 - (64'(d) << FRAC_BITS)) / 64'd10;
    return mag_t'(lim);
  endfunction

  localparam mag_t INT_LIMIT [10] = '{
    int_limit(0), int_limit(1), int_limit(2), int_limit(3), int_limit(4),
    int_limit(5), int_limit(6), int_limit(7), int_limit(8), int_limit(9)
  };

endpackage

// ===== rtl/core/dttf_front.sv =====
module dttf_front import dttf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output logic              push_valid,
  output entry_t            push_data
);

  logic at_first_r, at_first_nxt;
  logic in_frac_r, in_frac_nxt;
  logic neg_r, neg_nxt;
  logic err_r, err_nxt;
  logic sign_r, sign_nxt;
  logic digits_r, digits_nxt;
  logic is_digit;
  logic is_sign;
  op_t  op;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);

  // Classify the character against the format state of the current number.
  always_comb begin
    at_first_nxt = 1'b0;
    in_frac_nxt  = in_frac_r;
    neg_nxt      = neg_r;
    err_nxt      = err_r;
    sign_nxt     = sign_r;
    digits_nxt   = digits_r;
    op           = OP_NONE;
    if (!err_r) begin
      if (at_first_r && is_sign) begin
        sign_nxt = 1'b1;
        neg_nxt  = (char_code == CH_MINUS);
      end else if (is_digit) begin
        digits_nxt = 1'b1;
        op         = in_frac_r ? OP_FRAC : OP_INT;
      end else if (char_code == CH_POINT) begin
        if (in_frac_r) begin
          err_nxt = 1'b1;
        end else begin
          in_frac_nxt = 1'b1;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  // Only items that change the value or close a number go to the queue.
  always_comb begin
    push_valid      = take && ((op != OP_NONE) || last_char);
    push_data.op    = op;
    push_data.digit = DIGIT_W'(char_code - CH_ZERO);
    push_data.last  = last_char;
    push_data.bad   = err_nxt || (sign_nxt && !digits_nxt);
    push_data.neg   = neg_nxt;
  end

  // Format state; the last character returns it to the start of a number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_first_r <= 1'b1;
      in_frac_r  <= 1'b0;
      neg_r      <= 1'b0;
      err_r      <= 1'b0;
      sign_r     <= 1'b0;
      digits_r   <= 1'b0;
    end else if (take) begin
      if (last_char) begin
        at_first_r <= 1'b1;
        in_frac_r  <= 1'b0;
        neg_r      <= 1'b0;
        err_r      <= 1'b0;
        sign_r     <= 1'b0;
        digits_r   <= 1'b0;
      end else begin
        at_first_r <= at_first_nxt;
        in_frac_r  <= in_frac_nxt;
        neg_r      <= neg_nxt;
        err_r      <= err_nxt;
        sign_r     <= sign_nxt;
        digits_r   <= digits_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/dttf_queue.sv =====
module dttf_queue import dttf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t               slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;
  logic                 do_push;
  logic                 do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dttf_back.sv =====
module dttf_back import dttf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  entry_t             head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_bad_format,
  output logic               out_overflowed
);

  mag_t                      acc_r, acc_nxt;
  place_t                    place_r, place_nxt;
  logic                      sat_r, sat_nxt;
  logic                      out_valid_r;
  logic [VALUE_W-1:0]        value_r, value_nxt;
  logic                      bad_r;
  logic                      ovf_r;
  logic                      out_free;
  logic [MAG_W+2:0]          int_sum;
  logic [PLACE_W+DIGIT_W-1:0] frac_term;
  logic [MAG_W:0]            frac_sum;
  logic [DIV10_PROD_W-1:0]   div_prod;

  // A closing item needs the output register; others always go.
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = !empty && (!head.last || out_free);

  // Integer digit: times ten plus the digit, both by shift and add.
  assign int_sum = ((MAG_W+3)'(acc_r) << 3) + ((MAG_W+3)'(acc_r) << 1)
                 + ((MAG_W+3)'(head.digit) << FRAC_BITS);

  // Fraction digit: digit times the current place value.
  assign frac_term = (PLACE_W+DIGIT_W)'(head.digit) * (PLACE_W+DIGIT_W)'(place_r);
  assign frac_sum  = (MAG_W+1)'(acc_r) + (MAG_W+1)'(frac_term);

  // Place value of the following fraction digit.
  assign div_prod = DIV10_PROD_W'(place_r) * DIV10_PROD_W'(DIV10_MUL);

  // Next magnitude with saturation.
  always_comb begin
    acc_nxt   = acc_r;
    place_nxt = place_r;
    sat_nxt   = sat_r;
    case (head.op)
      OP_INT: begin
        if (acc_r > INT_LIMIT[head.digit]) begin
          acc_nxt = MAG_MAX;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = int_sum[MAG_W-1:0];
        end
      end
      OP_FRAC: begin
        place_nxt = div_prod[DIV10_SHIFT +: PLACE_W];
        if (frac_sum[MAG_W]) begin
          acc_nxt = MAG_MAX;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = frac_sum[MAG_W-1:0];
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Signed result of a closing item.
  always_comb begin
    if (head.bad) begin
      value_nxt = '0;
    end else if (head.neg) begin
      value_nxt = VALUE_W'(0) - VALUE_W'(acc_nxt);
    end else begin
      value_nxt = VALUE_W'(acc_nxt);
    end
  end

  // Running magnitude, cleared after each number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      place_r <= PLACE_FIRST;
      sat_r   <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        acc_r   <= '0;
        place_r <= PLACE_FIRST;
        sat_r   <= 1'b0;
      end else begin
        acc_r   <= acc_nxt;
        place_r <= place_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      value_r <= value_nxt;
      bad_r   <= head.bad;
      ovf_r   <= sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = value_r;
  assign out_bad_format = bad_r;
  assign out_overflowed = ovf_r;

endmodule

// ===== rtl/core/decimal_text_to_fixed_point_core.sv =====
// Decimal text to signed Q23.16 fixed point. Characters of a number come in
// one item per cycle while in_stall is low: an optional leading sign, then
// digits with at most one point; last_char marks the final character, and
// that item yields one result with the value, a format error flag and a
// saturation flag. Other items give no result. Throughput is one character
// per cycle while the queue has room; the front classifier takes a character
// in the cycle it is offered whenever its four-entry queue has room. Only
// digits and last characters are queued. The arithmetic stage retires one
// queued item per cycle; only a closing item that waits on a stalled result
// register holds the queue, and the queue is then full after three more
// queued items. A last character passes through the queue and then the
// result register before out_valid rises.
module decimal_text_to_fixed_point_core import dttf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_bad_format,
  output logic               out_overflowed
);

  logic   take;
  logic   push_valid;
  entry_t push_data;
  entry_t head;
  logic   empty;
  logic   full;
  logic   pop;

  assign in_stall = full;
  assign take     = in_valid && !full;

  // Classifier.
  dttf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .char_code  (in_char_code),
    .last_char  (in_last_char),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Queue between classifier and arithmetic.
  dttf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Arithmetic and result register.
  dttf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_bad_format (out_bad_format),
    .out_overflowed (out_overflowed)
  );

endmodule
